// ----- hw/rtl/oks_pkg.sv -----
// Shared constants and types for the ordered key set unit.
// Address and occupancy widths follow from CAPACITY; used by the top level and its key RAM instance.
// No dependencies.
package oks_pkg;

	localparam int CAPACITY = 256;
	localparam int KEY_W    = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int OCC_W    = $clog2(CAPACITY + 1);
	localparam int CNT_W    = 9;

	typedef logic [OCC_W-1:0]  occ_t;
	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_COUNT  = 2'd3;

	localparam cnt_t CNT_MAX = {CNT_W{1'b1}};

endpackage

// ----- hw/rtl/ordered_key_set_unit.sv -----
// Ordered key set unit: sorted store of distinct signed keys in a key RAM.
// Depends on oks_pkg and oks_ram.
//
//   channel   handshake         fields
//   -------   ---------------   ------------------------------------
//   command   start / busy      opcode[1:0], key[31:0] signed
//   result    done (strobe)     found, greater_count[8:0], full_drop
//
// A binary search over the RAM takes an S_MID read and an S_CMP compare for each
// halving step, then S_MID and S_HIT to check the final position; lookup and count
// end there. Insert and remove add a read state and a write state for each key moved
// (S_SHR and S_SHW, S_RMR and S_RMW), and insert S_PUT to write the new key; the
// single read port of the key RAM sets these steps.
// Reset empties the set at once; RAM words at or above occupancy are never taken as keys.
// The result strobe cannot be stalled; busy falls as done rises.
module ordered_key_set_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          opcode,
	input  logic signed [31:0]  key,
	output logic                done,
	output logic                found,
	output logic [8:0]          greater_count,
	output logic                full_drop
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MID  = 4'd1;
	localparam logic [3:0] S_CMP  = 4'd2;
	localparam logic [3:0] S_HIT  = 4'd3;
	localparam logic [3:0] S_SHR  = 4'd4;
	localparam logic [3:0] S_SHW  = 4'd5;
	localparam logic [3:0] S_PUT  = 4'd6;
	localparam logic [3:0] S_RMR  = 4'd7;
	localparam logic [3:0] S_RMW  = 4'd8;

	logic [3:0]     state_q;
	logic [1:0]     op_q;
	oks_pkg::key_t  key_q;
	oks_pkg::occ_t  occ_q;
	oks_pkg::occ_t  lo_q;
	oks_pkg::occ_t  hi_q;
	oks_pkg::occ_t  mid_q;
	oks_pkg::occ_t  idx_q;
	logic           done_q;
	logic           found_q;
	oks_pkg::cnt_t  count_q;
	logic           drop_q;

	logic [oks_pkg::OCC_W:0] mid_sum;
	oks_pkg::occ_t           mid;
	oks_pkg::occ_t           idx_m1;
	oks_pkg::occ_t           idx_p1;
	logic [oks_pkg::OCC_W:0] idx_p2;
	oks_pkg::occ_t           lo_p1;
	oks_pkg::occ_t           above;
	logic [oks_pkg::OCC_W+oks_pkg::CNT_W-1:0] above_ext;
	oks_pkg::cnt_t           count_sat;
	logic                    hit;

	logic           ram_we;
	oks_pkg::addr_t ram_waddr;
	oks_pkg::key_t  ram_wdata;
	logic           ram_re;
	oks_pkg::addr_t ram_raddr;
	oks_pkg::key_t  ram_rdata;

	oks_ram #(
		.WIDTH(oks_pkg::KEY_W),
		.DEPTH(oks_pkg::CAPACITY)
	) u_key_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[oks_pkg::OCC_W:1];
	assign idx_m1  = idx_q - oks_pkg::occ_t'(1);
	assign idx_p1  = idx_q + oks_pkg::occ_t'(1);
	assign idx_p2  = {1'b0, idx_q} + (oks_pkg::OCC_W+1)'(2);
	assign lo_p1   = lo_q + oks_pkg::occ_t'(1);

	// The search has ended when S_HIT is reached; lo_q is the lower bound.
	assign hit = (lo_q < occ_q) && (ram_rdata == key_q);
	assign above = occ_q - lo_q - oks_pkg::occ_t'(hit);
	assign above_ext = {{oks_pkg::CNT_W{1'b0}}, above};
	assign count_sat = (above_ext > {{oks_pkg::OCC_W{1'b0}}, oks_pkg::CNT_MAX}) ?
		oks_pkg::CNT_MAX : above_ext[oks_pkg::CNT_W-1:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[oks_pkg::ADDR_W-1:0];
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = lo_q[oks_pkg::ADDR_W-1:0];
		unique case (state_q) inside
			S_MID: begin
				ram_re = 1'b1;
				if (lo_q < hi_q) begin
					ram_raddr = mid[oks_pkg::ADDR_W-1:0];
				end
			end
			S_SHR: begin
				ram_re    = 1'b1;
				ram_raddr = idx_m1[oks_pkg::ADDR_W-1:0];
			end
			S_SHW, S_RMW: begin
				ram_we = 1'b1;
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = lo_q[oks_pkg::ADDR_W-1:0];
				ram_wdata = key_q;
			end
			S_RMR: begin
				ram_re    = 1'b1;
				ram_raddr = idx_p1[oks_pkg::ADDR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_MID;
					end
				end
				S_MID: begin
					state_q <= (lo_q < hi_q) ? S_CMP : S_HIT;
				end
				S_CMP: begin
					state_q <= S_MID;
				end
				S_HIT: begin
					case (op_q)
						oks_pkg::OP_INSERT: begin
							if (hit || occ_q == oks_pkg::occ_t'(oks_pkg::CAPACITY)) begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
							end else begin
								state_q <= (occ_q > lo_q) ? S_SHR : S_PUT;
							end
						end
						oks_pkg::OP_REMOVE: begin
							if (!hit) begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
							end else if (lo_p1 < occ_q) begin
								state_q <= S_RMR;
							end else begin
								occ_q   <= occ_q - oks_pkg::occ_t'(1);
								state_q <= S_IDLE;
								done_q  <= 1'b1;
							end
						end
						default: begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
					endcase
				end
				S_SHR: begin
					state_q <= S_SHW;
				end
				S_SHW: begin
					state_q <= (idx_m1 > lo_q) ? S_SHR : S_PUT;
				end
				S_PUT: begin
					occ_q   <= occ_q + oks_pkg::occ_t'(1);
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				S_RMR: begin
					state_q <= S_RMW;
				end
				S_RMW: begin
					if (idx_p2 < {1'b0, occ_q}) begin
						state_q <= S_RMR;
					end else begin
						occ_q   <= occ_q - oks_pkg::occ_t'(1);
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command word, search bounds, shift index and result words.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q  <= opcode;
				key_q <= key;
				lo_q  <= '0;
				hi_q  <= occ_q;
			end
			S_MID: begin
				mid_q <= mid;
			end
			S_CMP: begin
				if ($signed(ram_rdata) < $signed(key_q)) begin
					lo_q <= mid_q + oks_pkg::occ_t'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			S_HIT: begin
				found_q <= hit;
				count_q <= (op_q == oks_pkg::OP_COUNT) ? count_sat : '0;
				drop_q  <= (op_q == oks_pkg::OP_INSERT) && !hit &&
					(occ_q == oks_pkg::occ_t'(oks_pkg::CAPACITY));
				idx_q   <= (op_q == oks_pkg::OP_INSERT) ? occ_q : lo_q;
			end
			S_SHW: begin
				idx_q <= idx_m1;
			end
			S_RMW: begin
				idx_q <= idx_p1;
			end
			default: begin
			end
		endcase
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign found         = found_q;
	assign greater_count = count_q;
	assign full_drop     = drop_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= oks_pkg::occ_t'(oks_pkg::CAPACITY))
		else $error("occupancy above capacity");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a preceding operation");

	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && full_drop |-> !found && greater_count == '0)
		else $error("dropped insert reported a hit or a count");

endmodule

// ----- hw/rtl/oks_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module oks_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- tb/ordered_key_set_unit_test.sv -----
// Self-checking testbench for ordered_key_set_unit: a directed script, then random
// fill and drain sequences, checked against typed results or a sorted-queue model of the set.
// Depends on oks_pkg and the ordered_key_set_unit RTL.
`timescale 1ns / 1ps

module ordered_key_set_unit_test;

	localparam int RANDOM_WORDS = 2000;
	localparam int CYCLE_LIMIT  = 8_000_000;
	localparam int DRAIN_CYCLES = 600;
	localparam int SCRIPT_LEN   = 24;

	localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic found;
		oks_pkg::cnt_t greater_count;
		logic full_drop;
	} set_result_t;

	typedef struct {
		logic [1:0]         op;
		logic signed [31:0] k;
		bit                 fixed;
		set_result_t        res;
	} script_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         opcode = oks_pkg::OP_INSERT;
	logic signed [31:0] key = '0;
	logic               done;
	logic               found;
	logic [8:0]         greater_count;
	logic               full_drop;

	// Keys currently held by the set, ascending.
	logic signed [31:0] held_keys[$];
	set_result_t        pending_results[$];
	int                 idle_pct = 16;
	int                 fail_count = 0;
	int                 cycle_count = 0;

	// Rows with a typed result are checked against it; the rest against the model.
	script_row_t script[SCRIPT_LEN] = '{
		'{oks_pkg::OP_LOOKUP, 32'sd0,          1'b1, '{1'b0, 9'd0, 1'b0}},
		'{oks_pkg::OP_COUNT,  KEY_MIN,         1'b1, '{1'b0, 9'd0, 1'b0}},
		'{oks_pkg::OP_REMOVE, 32'sd5,          1'b1, '{1'b0, 9'd0, 1'b0}},
		'{oks_pkg::OP_INSERT, KEY_MIN,         1'b1, '{1'b0, 9'd0, 1'b0}},
		'{oks_pkg::OP_INSERT, KEY_MIN,         1'b1, '{1'b1, 9'd0, 1'b0}},
		'{oks_pkg::OP_INSERT, KEY_MAX,         1'b1, '{1'b0, 9'd0, 1'b0}},
		'{oks_pkg::OP_COUNT,  KEY_MIN,         1'b1, '{1'b1, 9'd1, 1'b0}},
		'{oks_pkg::OP_COUNT,  KEY_MAX,         1'b1, '{1'b1, 9'd0, 1'b0}},
		'{oks_pkg::OP_COUNT,  -32'sd1,         1'b1, '{1'b0, 9'd1, 1'b0}},
		'{oks_pkg::OP_INSERT, 32'sd0,          1'b1, '{1'b0, 9'd0, 1'b0}},
		'{oks_pkg::OP_INSERT, -32'sd1,         1'b1, '{1'b0, 9'd0, 1'b0}},
		'{oks_pkg::OP_INSERT, 32'sd1,          1'b1, '{1'b0, 9'd0, 1'b0}},
		'{oks_pkg::OP_COUNT,  -32'sd1,         1'b0, '0},
		'{oks_pkg::OP_LOOKUP, 32'sd1,          1'b0, '0},
		'{oks_pkg::OP_REMOVE, 32'sd0,          1'b0, '0},
		'{oks_pkg::OP_LOOKUP, 32'sd0,          1'b0, '0},
		'{oks_pkg::OP_COUNT,  KEY_MIN + 1,     1'b0, '0},
		'{oks_pkg::OP_REMOVE, KEY_MIN,         1'b1, '{1'b1, 9'd0, 1'b0}},
		'{oks_pkg::OP_REMOVE, KEY_MIN,         1'b1, '{1'b0, 9'd0, 1'b0}},
		'{oks_pkg::OP_INSERT, 32'sh5555_5555,  1'b0, '0},
		'{oks_pkg::OP_INSERT, 32'shAAAA_AAAA,  1'b0, '0},
		'{oks_pkg::OP_COUNT,  32'shAAAA_AAAA,  1'b0, '0},
		'{oks_pkg::OP_REMOVE, KEY_MAX,         1'b1, '{1'b1, 9'd0, 1'b0}},
		'{oks_pkg::OP_LOOKUP, KEY_MAX,         1'b1, '{1'b0, 9'd0, 1'b0}}
	};

	ordered_key_set_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.key           (key),
		.done          (done),
		.found         (found),
		.greater_count (greater_count),
		.full_drop     (full_drop)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Applies one operation to the model set and gives the result it should produce.
	task automatic apply_to_set(input logic [1:0] op, input logic signed [31:0] k,
			output set_result_t res);
		int pos;
		int above;
		bit hit;
		pos = 0;
		while (pos < held_keys.size() && held_keys[pos] < k)
			pos++;
		hit = (pos < held_keys.size()) && (held_keys[pos] == k);
		res = '{hit, 9'd0, 1'b0};
		case (op)
			oks_pkg::OP_INSERT: begin
				if (!hit) begin
					if (held_keys.size() >= oks_pkg::CAPACITY)
						res.full_drop = 1'b1;
					else
						held_keys.insert(pos, k);
				end
			end
			oks_pkg::OP_REMOVE: begin
				if (hit)
					held_keys.delete(pos);
			end
			oks_pkg::OP_COUNT: begin
				above = held_keys.size() - (hit ? pos + 1 : pos);
				res.greater_count = (above > oks_pkg::CNT_MAX) ?
					oks_pkg::CNT_MAX : oks_pkg::cnt_t'(above);
			end
			default: ;
		endcase
	endtask

	// Drives one command word, honouring the sender idle rate, and records what it
	// should return once the unit has taken it.
	task automatic send_word(input logic [1:0] op, input logic signed [31:0] k,
			input bit fixed, input set_result_t fixed_res);
		set_result_t predicted;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start  <= 1'b1;
		opcode <= op;
		key    <= k;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		apply_to_set(op, k, predicted);
		pending_results.push_back(fixed ? fixed_res : predicted);
	endtask

	task automatic wait_for_results;
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	function automatic logic signed [31:0] extreme_key();
		case ($urandom_range(6))
			0: return KEY_MIN;
			1: return KEY_MIN + 1;
			2: return -32'sd1;
			3: return 32'sd0;
			4: return 32'sd1;
			5: return KEY_MAX - 1;
			default: return KEY_MAX;
		endcase
	endfunction

	// Most lookups, removes and counts aim at held keys or their neighbours so that
	// hits are common; inserts mostly bring fresh keys.
	function automatic logic signed [31:0] pick_key(logic [1:0] op);
		int r;
		logic signed [31:0] base;
		r = $urandom_range(99);
		if (held_keys.size() != 0)
			base = held_keys[$urandom_range(held_keys.size() - 1)];
		else
			base = $urandom;
		if (op == oks_pkg::OP_INSERT) begin
			if (r < 15)
				return base;
			if (r < 25)
				return extreme_key();
			return $urandom;
		end
		if (r < 60)
			return base;
		if (r < 75)
			return $urandom_range(1) ? base + 1 : base - 1;
		if (r < 85)
			return extreme_key();
		return $urandom;
	endfunction

	function automatic logic [1:0] pick_op(bit filling);
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return filling ? oks_pkg::OP_INSERT : oks_pkg::OP_REMOVE;
		if (r < 87)
			return oks_pkg::OP_LOOKUP;
		if (r < 94)
			return oks_pkg::OP_COUNT;
		return filling ? oks_pkg::OP_REMOVE : oks_pkg::OP_INSERT;
	endfunction

	initial begin
		bit filling;
		int full_words;
		logic [1:0] op;
		filling = 1'b1;
		full_words = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_word(script[i].op, script[i].k, script[i].fixed, script[i].res);
		wait_for_results();

		// Alternate between filling the set to capacity (holding it full for a while
		// so that inserts get dropped) and draining it back to empty.
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == RANDOM_WORDS / 3) begin
				wait_for_results();
				idle_pct = 60;
			end else if (i == 2 * RANDOM_WORDS / 3) begin
				wait_for_results();
				idle_pct = 0;
			end
			if (filling && held_keys.size() == oks_pkg::CAPACITY)
				full_words++;
			if (full_words > 40) begin
				filling = 1'b0;
				full_words = 0;
			end else if (!filling && held_keys.size() == 0) begin
				filling = 1'b1;
			end
			op = pick_op(filling);
			send_word(op, pick_key(op), 1'b0, '0);
		end

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) begin
		set_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: expected no result word, got found=%0d count=%0d drop=%0d",
					$time, found, greater_count, full_drop);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (found !== want.found) begin
					$display("%0t: found expected %0d, got %0d", $time, want.found, found);
					fail_count++;
				end
				if (greater_count !== want.greater_count) begin
					$display("%0t: greater_count expected %0d, got %0d", $time,
						want.greater_count, greater_count);
					fail_count++;
				end
				if (full_drop !== want.full_drop) begin
					$display("%0t: full_drop expected %0d, got %0d", $time,
						want.full_drop, full_drop);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				pending_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

endmodule

// ----- files.f -----
hw/rtl/oks_pkg.sv
hw/rtl/oks_ram.sv
hw/rtl/ordered_key_set_unit.sv
tb/ordered_key_set_unit_test.sv
